FILE: rtl/ssss_pkg.sv
// ----------------------------------------------------------------------------
// ssss_pkg
// Types and codes shared by the sample set sort and statistics block.
// ----------------------------------------------------------------------------
package ssss_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned RES_W    = 48;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MEAN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MEDIAN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SD     = 3'd4;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [RES_W-1:0]  result_value;
    logic              dropped_samples;
    logic              empty_set;
    logic              last;
  } out_item_t;

endpackage

FILE: rtl/ssss_ram.sv
// ----------------------------------------------------------------------------
// ssss_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/ssss_div.sv
// ----------------------------------------------------------------------------
// ssss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssss_div #(
  parameter int unsigned N_W = 48,
  parameter int unsigned D_W = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(N_W + 1);

  logic          run_q, run_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N_W-1:0] acc_q, acc_d;
  logic [D_W-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [D_W:0]   rem_sh, rem_n;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q, acc_q[N_W-1]};
    ge     = rem_sh >= {1'b0, dv_q};
    rem_n  = ge ? rem_sh - {1'b0, dv_q} : rem_sh;
    run_d  = run_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(N_W);
      acc_d = dividend_i;
      rem_d = '0;
      dv_d  = divisor_i;
    end else if (run_q) begin
      acc_d = {acc_q[N_W-2:0], ge};
      rem_d = rem_n[D_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

FILE: rtl/ssss_front.sv
// ----------------------------------------------------------------------------
// ssss_front
// Accepts transactions and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ssss_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ssss_pkg::in_item_t item_i,
  output logic               cmd_valid_o,
  output ssss_pkg::in_item_t cmd_o,
  input  logic               cmd_pop_i
);

  ssss_pkg::in_item_t slot_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] fill_q, fill_d;
  logic       push;

  assign busy        = fill_q == 2'd2;
  assign push        = start && !busy;
  assign cmd_valid_o = fill_q != 2'd0;
  assign cmd_o       = slot_q[rp_q];

  always_comb begin
    wp_d   = push ? ~wp_q : wp_q;
    rp_d   = cmd_pop_i ? ~rp_q : rp_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= item_i;
    end
  end

endmodule

FILE: rtl/ssss_back.sv
// ----------------------------------------------------------------------------
// ssss_back
// Stores samples; on close sorts, emits samples and computes the statistics (zero when empty).
// ----------------------------------------------------------------------------
module ssss_back #(
  parameter int unsigned MAX_SAMPLES = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ssss_pkg::in_item_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                res_valid_o,
  output ssss_pkg::out_item_t res_o
);

  localparam int unsigned AW    = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = SB + CNT_W;
  localparam int unsigned DEV_W = 2 * SB + CNT_W;
  localparam int unsigned QM_W  = DEV_W + CNT_W;
  localparam int unsigned Q_W   = QM_W + 8;
  localparam int unsigned N2_W  = 2 * CNT_W;
  localparam int unsigned SQ_W  = Q_W + (Q_W % 2);
  localparam int unsigned RT_W  = SQ_W / 2;
  localparam int unsigned RM_W  = RT_W + 3;
  localparam int unsigned SC_W  = $clog2(RT_W + 1);
  localparam int unsigned VW    = (Q_W > ssss_pkg::RES_W) ? Q_W : ssss_pkg::RES_W;
  localparam int unsigned RW    = ssss_pkg::RES_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SI_RD  = 5'd1;
  localparam logic [4:0] S_SI_LD  = 5'd2;
  localparam logic [4:0] S_SJ_RD  = 5'd3;
  localparam logic [4:0] S_SJ_CMP = 5'd4;
  localparam logic [4:0] S_SI_END = 5'd5;
  localparam logic [4:0] S_EM_RD  = 5'd6;
  localparam logic [4:0] S_EM_OUT = 5'd7;
  localparam logic [4:0] S_MN_GO  = 5'd8;
  localparam logic [4:0] S_MN_WT  = 5'd9;
  localparam logic [4:0] S_MUL    = 5'd10;
  localparam logic [4:0] S_FRAC   = 5'd11;
  localparam logic [4:0] S_DV_RD  = 5'd12;
  localparam logic [4:0] S_DV_SUB = 5'd13;
  localparam logic [4:0] S_DV_SQ  = 5'd14;
  localparam logic [4:0] S_DV_ACC = 5'd15;
  localparam logic [4:0] S_QM     = 5'd16;
  localparam logic [4:0] S_VR_GO  = 5'd17;
  localparam logic [4:0] S_VR_WT  = 5'd18;
  localparam logic [4:0] S_SQRT   = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic             ovf_q, ovf_d, empty_q, empty_d;
  logic [SB-1:0]    cur_q, cur_d, med_a_q, med_a_d, med_b_q, med_b_d;
  logic [SB-1:0]    m_q, m_d, d_q, d_d;
  logic [SUM_W-1:0] sum_q, sum_d, prod_q, prod_d;
  logic [SUM_W+7:0] mean_q, mean_d;
  logic [N2_W-1:0]  nsq_q, nsq_d, fsq_q, fsq_d;
  logic [2*SB-1:0]  sq_q, sq_d;
  logic [DEV_W-1:0] dev_q, dev_d;
  logic [QM_W-1:0]  qm_q, qm_d;
  logic [VW-1:0]    var_q, var_d;
  logic [SQ_W-1:0]  rad_q, rad_d;
  logic [RM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RT_W-1:0]  root_q, root_d;
  logic [SC_W-1:0]  sc_q, sc_d;
  logic [1:0]       k_q, k_d;
  logic             rv_q, rv_d;
  ssss_pkg::out_item_t res_q, res_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [SB-1:0]    wdata, rdata;
  logic             div_start, div_done;
  logic [Q_W-1:0]   div_n, div_q;
  logic [N2_W-1:0]  div_d;
  logic [CNT_W-1:0] half, f_n;
  logic [SUM_W-1:0] f_w;
  logic [SB:0]      med2;
  logic [RW-1:0]    stat;

  ssss_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ssss_div #(.N_W(Q_W), .D_W(N2_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  assign half = cnt_q >> 1;
  assign f_w  = sum_q - prod_q;
  assign f_n  = f_w[CNT_W-1:0];
  assign med2 = cnt_q[0] ? {med_b_q, 1'b0} : {1'b0, med_a_q} + {1'b0, med_b_q};
  assign rem_sh = {rem_q[RM_W-3:0], rad_q[SQ_W-1:SQ_W-2]};
  assign trial  = RM_W'({root_q, 2'b01});

  always_comb begin
    case (k_q)
      2'd0:    stat = RW'(mean_q);
      2'd1:    stat = RW'(med2);
      2'd2:    stat = (var_q > VW'({RW{1'b1}})) ? {RW{1'b1}} : RW'(var_q);
      default: stat = RW'(root_q);
    endcase
  end

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;    i_d = i_q;      j_d = j_q;
    ovf_d = ovf_q;      empty_d = empty_q; cur_d = cur_q;
    med_a_d = med_a_q;  med_b_d = med_b_q; m_d = m_q;      d_d = d_q;
    sum_d = sum_q;      prod_d = prod_q;  mean_d = mean_q; nsq_d = nsq_q;
    fsq_d = fsq_q;      sq_d = sq_q;      dev_d = dev_q;  qm_d = qm_q;
    var_d = var_q;      rad_d = rad_q;    rem_d = rem_q;  root_d = root_q;
    sc_d = sc_q;        k_d = k_q;        rv_d = 1'b0;    res_d = res_q;
    we = 1'b0;  waddr = cnt_q[AW-1:0];  wdata = cur_q;
    re = 1'b0;  raddr = i_q[AW-1:0];
    div_start = 1'b0;
    div_n = Q_W'({sum_q, 8'd0});
    div_d = N2_W'(cnt_q);
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.action == ssss_pkg::ACT_ADD) begin
            if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
              we    = 1'b1;
              wdata = SB'(cmd_i.sample);
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else if (cnt_q == '0) begin
            empty_d = 1'b1;
            k_d     = 2'd0;
            state_d = S_OUT;
          end else begin
            i_d     = '0;
            sum_d   = '0;
            state_d = (cnt_q == CNT_W'(1)) ? S_EM_RD : S_SI_RD;
          end
        end
      end
      S_SI_RD: begin
        re      = 1'b1;
        state_d = S_SI_LD;
      end
      S_SI_LD: begin
        cur_d   = rdata;
        j_d     = i_q + 1'b1;
        state_d = S_SJ_RD;
      end
      S_SJ_RD: begin
        re      = 1'b1;
        raddr   = j_q[AW-1:0];
        state_d = S_SJ_CMP;
      end
      S_SJ_CMP: begin
        if (cur_q > rdata) begin
          we    = 1'b1;
          waddr = j_q[AW-1:0];
          cur_d = rdata;
        end
        j_d     = j_q + 1'b1;
        state_d = (j_q + 1'b1 == cnt_q) ? S_SI_END : S_SJ_RD;
      end
      S_SI_END: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        if (i_q + 1'b1 == cnt_q - 1'b1) begin
          i_d     = '0;
          state_d = S_EM_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SI_RD;
        end
      end
      S_EM_RD: begin
        re      = 1'b1;
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        rv_d  = 1'b1;
        res_d = '{result_kind: ssss_pkg::KIND_SAMPLE, result_value: RW'(rdata),
                  dropped_samples: ovf_q, empty_set: 1'b0, last: 1'b0};
        sum_d = sum_q + SUM_W'(rdata);
        if (i_q == half - 1'b1) med_a_d = rdata;
        if (i_q == half) med_b_d = rdata;
        i_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 == cnt_q) ? S_MN_GO : S_EM_RD;
      end
      S_MN_GO: begin
        div_start = 1'b1;
        state_d   = S_MN_WT;
      end
      S_MN_WT: begin
        if (div_done) begin
          mean_d  = div_q[SUM_W+7:0];
          m_d     = div_q[SB+7:8];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = m_q * cnt_q;
        nsq_d   = cnt_q * cnt_q;
        state_d = S_FRAC;
      end
      S_FRAC: begin
        fsq_d   = f_n * f_n;
        dev_d   = '0;
        i_d     = '0;
        state_d = S_DV_RD;
      end
      S_DV_RD: begin
        re      = 1'b1;
        state_d = S_DV_SUB;
      end
      S_DV_SUB: begin
        d_d     = (rdata > m_q) ? rdata - m_q : m_q - rdata;
        state_d = S_DV_SQ;
      end
      S_DV_SQ: begin
        sq_d    = d_q * d_q;
        state_d = S_DV_ACC;
      end
      S_DV_ACC: begin
        dev_d   = dev_q + DEV_W'(sq_q);
        i_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 == cnt_q) ? S_QM : S_DV_RD;
      end
      S_QM: begin
        qm_d    = dev_q * cnt_q;
        state_d = S_VR_GO;
      end
      S_VR_GO: begin
        div_start = 1'b1;
        div_n     = {qm_q - QM_W'(fsq_q), 8'd0};
        div_d     = nsq_q;
        state_d   = S_VR_WT;
      end
      S_VR_WT: begin
        if (div_done) begin
          var_d   = VW'(div_q);
          rad_d   = SQ_W'(div_q);
          rem_d   = '0;
          root_d  = '0;
          sc_d    = SC_W'(RT_W);
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RT_W-2:0], 1'b0};
        end
        rad_d = {rad_q[SQ_W-3:0], 2'b00};
        sc_d  = sc_q - 1'b1;
        if (sc_q == SC_W'(1)) begin
          k_d     = 2'd0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        rv_d  = 1'b1;
        res_d = '{result_kind: ssss_pkg::KIND_MEAN + ssss_pkg::KIND_W'(k_q),
                  result_value: empty_q ? '0 : stat,
                  dropped_samples: ovf_q, empty_set: empty_q,
                  last: k_q == 2'd3};
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          empty_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      empty_q <= 1'b0;
      rv_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      empty_q <= empty_d;
      rv_q    <= rv_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      sc_q    <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  med_a_q <= med_a_d;  med_b_q <= med_b_d;
    m_q <= m_d;      d_q <= d_d;          sum_q <= sum_d;
    prod_q <= prod_d; mean_q <= mean_d;   nsq_q <= nsq_d;
    fsq_q <= fsq_d;  sq_q <= sq_d;        dev_q <= dev_d;
    qm_q <= qm_d;    var_q <= var_d;      rad_q <= rad_d;
    rem_q <= rem_d;  root_q <= root_d;    res_q <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/sample_set_sort_and_statistics_top.sv
// ----------------------------------------------------------------------------
// sample_set_sort_and_statistics_top
// Sample store with exchange sort, mean, median, variance and deviation.
// ----------------------------------------------------------------------------
// Add transactions: one per cycle sustained while no close is in progress.
// Close time is set by the single RAM read port in the sort loop and the
// bit-serial divider and square root; the divider width is
// 2*SAMPLE_BITS + 2*clog2(MAX_SAMPLES+1) + 8.
// busy is high while the two-entry queue is full; results cannot be stalled.
// Reset is asynchronous and clears count and flags; store contents undefined.
module sample_set_sort_and_statistics_top #(
  parameter int unsigned MAX_SAMPLES = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ssss_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output ssss_pkg::out_item_t result_o
);

  logic               cmd_valid, cmd_pop;
  ssss_pkg::in_item_t cmd;

  ssss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  ssss_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

  a_last_is_sd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> result_o.result_kind == ssss_pkg::KIND_SD)
    else $error("last flag on a result other than the deviation");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.empty_set |->
      result_o.result_kind != ssss_pkg::KIND_SAMPLE && result_o.result_value == '0)
    else $error("empty set produced a sample or nonzero statistic");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.result_kind == ssss_pkg::KIND_SAMPLE |->
      (result_o.result_value >> SAMPLE_BITS) == '0)
    else $error("sorted sample exceeds sample width");

endmodule

FILE: bench/sample_set_sort_and_statistics_top_test.sv
// ----------------------------------------------------------------------------
// sample_set_sort_and_statistics_top_test
// Loads sample sets of random size and content, closes them, and checks the
// sorted samples and fixed-point statistics against an in-bench predictor.
// ----------------------------------------------------------------------------
module sample_set_sort_and_statistics_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned SAMPLE_W = ssss_pkg::SAMPLE_W;
  localparam int unsigned KIND_W   = ssss_pkg::KIND_W;
  localparam int unsigned RES_W    = ssss_pkg::RES_W;

  class stats_scoreboard;
    logic [SAMPLE_W-1:0]  set_store[CAPACITY];
    int unsigned          set_len;
    logic                 dropped;
    ssss_pkg::out_item_t  expected_q[$];
    int unsigned          mismatches;

    function new();
      set_len    = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, logic [RES_W-1:0] value,
                              logic empty, logic is_last);
      ssss_pkg::out_item_t r;
      r.result_kind     = kind;
      r.result_value    = value;
      r.dropped_samples = dropped;
      r.empty_set       = empty;
      r.last            = is_last;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function logic [RES_W-1:0] isqrt40(logic [127:0] v);
      logic [63:0] root;
      logic [63:0] cand;
      root = 0;
      for (int b = 39; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= v) root = cand;
      end
      return root[RES_W-1:0];
    endfunction

    function void note_input(ssss_pkg::in_item_t it);
      logic [SAMPLE_W-1:0] t;
      logic [127:0]        sum, sumsq, num, q;
      logic [RES_W-1:0]    mean8, med2, var8, sd16;
      int unsigned         n;
      if (it.action == ssss_pkg::ACT_ADD) begin
        if (set_len < CAPACITY) begin
          set_store[set_len] = it.sample;
          set_len++;
        end else begin
          dropped = 1'b1;
        end
        return;
      end
      n = set_len;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (set_store[i] > set_store[j]) begin
            t = set_store[i];
            set_store[i] = set_store[j];
            set_store[j] = t;
          end
      sum   = 0;
      sumsq = 0;
      for (int i = 0; i < n; i++) begin
        push_result(ssss_pkg::KIND_SAMPLE, RES_W'(set_store[i]), 1'b0, 1'b0);
        sum   += set_store[i];
        sumsq += 128'(set_store[i]) * set_store[i];
      end
      if (n == 0) begin
        mean8 = 0; med2 = 0; var8 = 0; sd16 = 0;
      end else begin
        mean8 = RES_W'((sum << 8) / n);
        if (n % 2) med2 = RES_W'(set_store[n/2]) << 1;
        else med2 = RES_W'(set_store[n/2-1]) + RES_W'(set_store[n/2]);
        num  = sumsq * n - sum * sum;
        q    = (num << 8) / (n * n);
        sd16 = isqrt40(q);
        var8 = (q >> RES_W) != 0 ? {RES_W{1'b1}} : q[RES_W-1:0];
      end
      push_result(ssss_pkg::KIND_MEAN,   mean8, n == 0, 1'b0);
      push_result(ssss_pkg::KIND_MEDIAN, med2,  n == 0, 1'b0);
      push_result(ssss_pkg::KIND_VAR,    var8,  n == 0, 1'b0);
      push_result(ssss_pkg::KIND_SD,     sd16,  n == 0, 1'b1);
      set_len = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(ssss_pkg::out_item_t got);
      ssss_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind || got.result_value !== want.result_value
          || got.dropped_samples !== want.dropped_samples
          || got.empty_set !== want.empty_set || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ssss_pkg::in_item_t  item;
  logic                result_valid;
  ssss_pkg::out_item_t result;

  stats_scoreboard sb;
  int unsigned     burst_left;

  sample_set_sort_and_statistics_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && result_valid) sb.check_result(result);
  end

  task automatic send_item(logic act, logic [SAMPLE_W-1:0] value);
    ssss_pkg::in_item_t it;
    int unsigned        gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      @(negedge clk);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) burst_left = 40;
    end else begin
      @(negedge clk);
    end
    it.action = act;
    it.sample = value;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic add_sample(logic [SAMPLE_W-1:0] value);
    send_item(ssss_pkg::ACT_ADD, value);
  endtask

  task automatic close_set();
    send_item(ssss_pkg::ACT_CLOSE, SAMPLE_W'($urandom()));
  endtask

  task automatic random_set(int unsigned len, int unsigned style);
    for (int i = 0; i < len; i++)
      case (style)
        0: add_sample(SAMPLE_W'($urandom_range(0, 65535)));
        1: add_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        2: add_sample(SAMPLE_W'(16'h8000 + $urandom_range(0, 15)));
        default: add_sample(SAMPLE_W'($urandom_range(0, 255)));
      endcase
    close_set();
  endtask

  initial begin
    sb         = new();
    burst_left = 0;
    start      = 1'b0;
    item       = '0;
    rst_n      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty set, extremes, odd and even counts, full store and overflow
    close_set();
    add_sample(16'hFFFF); add_sample(16'h0000); close_set();
    add_sample(16'h1234); close_set();
    add_sample(16'd7); add_sample(16'd3); add_sample(16'd9); close_set();
    for (int i = 0; i < 34; i++) add_sample(SAMPLE_W'(16'hFFFF - i));
    close_set();
    for (int i = 0; i < 32; i++) add_sample(i[0] ? 16'hFFFF : 16'h0000);
    close_set();

    while (sb.set_len == 0 && burst_left < 1000) begin
      int unsigned total;
      total = 0;
      while (total < 200) begin
        int unsigned len;
        len = $urandom_range(0, 4) == 0 ? $urandom_range(30, 36) : $urandom_range(0, 12);
        random_set(len, $urandom_range(0, 4));
        total += len + 1;
      end
      break;
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
